@@ sv/rtcu_pkg.sv @@
package rtcu_pkg;

    localparam int CSR_SPACE = 4096;
    localparam int AW = $clog2(CSR_SPACE);

    localparam logic [2:0] OP_CSR  = 3'd0;
    localparam logic [2:0] OP_TRAP = 3'd1;
    localparam logic [2:0] OP_SRET = 3'd2;
    localparam logic [2:0] OP_MRET = 3'd3;
    localparam logic [2:0] OP_POLL = 3'd4;

    localparam logic [11:0] A_SSTATUS = 12'h100;
    localparam logic [11:0] A_SIE     = 12'h104;
    localparam logic [11:0] A_STVEC   = 12'h105;
    localparam logic [11:0] A_SEPC    = 12'h141;
    localparam logic [11:0] A_SCAUSE  = 12'h142;
    localparam logic [11:0] A_STVAL   = 12'h143;
    localparam logic [11:0] A_SIP     = 12'h144;
    localparam logic [11:0] A_MSTATUS = 12'h300;
    localparam logic [11:0] A_MEDELEG = 12'h302;
    localparam logic [11:0] A_MIDELEG = 12'h303;
    localparam logic [11:0] A_MIE     = 12'h304;
    localparam logic [11:0] A_MTVEC   = 12'h305;
    localparam logic [11:0] A_MEPC    = 12'h341;
    localparam logic [11:0] A_MCAUSE  = 12'h342;
    localparam logic [11:0] A_MTVAL   = 12'h343;
    localparam logic [11:0] A_MIP     = 12'h344;

    localparam logic [63:0] SS_WMASK = 64'h00000000000c6122;
    localparam logic [63:0] SS_RMASK = SS_WMASK | (64'h3 << 15) | (64'h1 << 63)
                                       | (64'h3 << 32);
    localparam logic [63:0] S_IRQ_MASK  = 64'h222;
    localparam logic [63:0] EDELEG_MASK = 64'hbbff;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] csr_addr;
        logic        want_read;
        logic        want_write;
        logic [63:0] write_data;
        logic [3:0]  trap_cause;
        logic        trap_is_interrupt;
        logic [63:0] current_pc;
    } req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic [63:0] next_pc;
        logic        redirect;
        logic        fault;
        logic [1:0]  mode_now;
    } rsp_t;

endpackage

@@ sv/rtcu_raw_store.sv @@
module rtcu_raw_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [11:0]          rd_addr,
    input  logic                 wr_en,
    input  logic [11:0]          wr_addr,
    input  logic [63:0]          wr_data,
    output logic                 clearing,
    output logic [63:0]          rd_data
);
    import rtcu_pkg::*;

    logic [63:0]   mem [CSR_SPACE];
    logic [AW:0]   clr_cnt_reg;
    logic [63:0]   rd_data_reg;

    assign clearing = (clr_cnt_reg != (AW+1)'(CSR_SPACE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // clearing pass first, then normal writes
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_cnt_reg[AW-1:0]] <= '0;
        end
        else if (wr_en && ({1'b0, wr_addr} < 13'(CSR_SPACE)))
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ sv/riscv_trap_and_csr_unit.sv @@
// Privileged trap and CSR unit for machine and supervisor modes. One request is accepted per
// cycle while s_tready is high; it waits in stage 1 for the raw CSR store's registered read, then
// its result is registered in the output register, and a skid register holds the one result that
// is in flight when the output stalls, so s_tready drops while the output is stalled with both
// the output register and the pipeline stage occupied. Named CSRs live in flip-flops; all other
// addresses go to a 4096-entry store cleared after reset one entry per cycle, so s_tready stays
// low while clearing. A raw write directly followed by a read of the same address is forwarded.
module riscv_trap_and_csr_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // opcode[2:0], csr_addr[14:3], want_read[15], want_write[16], write_data[80:17],
    // trap_cause[84:81], trap_is_interrupt[85], current_pc[149:86], zero fill
    input  logic [151:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // read_data[63:0], next_pc[127:64], redirect[128], fault[129], mode_now[131:130], zero fill
    output logic [135:0]  m_tdata
);
    import rtcu_pkg::*;

    req_t req;
    assign req.opcode            = s_tdata[2:0];
    assign req.csr_addr          = s_tdata[14:3];
    assign req.want_read         = s_tdata[15];
    assign req.want_write        = s_tdata[16];
    assign req.write_data        = s_tdata[80:17];
    assign req.trap_cause        = s_tdata[84:81];
    assign req.trap_is_interrupt = s_tdata[85];
    assign req.current_pc        = s_tdata[149:86];

    // stage 1: request waiting for raw read data
    logic  s1_valid_reg;
    req_t  s1_req_reg;
    // output register and skid register
    logic  out_valid_reg, skid_valid_reg;
    rsp_t  out_reg, skid_reg;

    logic  clearing;
    logic  advance;
    assign s_tready = !clearing && !skid_valid_reg
                      && !(s1_valid_reg && out_valid_reg && !m_tready);
    assign advance  = s1_valid_reg;

    logic  acc;
    assign acc = s_tvalid && s_tready;

    // raw store: read on accept, write when stage 1 retires
    logic [63:0] raw_rd;
    logic        raw_we;
    logic [63:0] fwd_data_reg;
    logic        fwd_hit_reg;

    logic [1:0]  priv_reg, priv_next;
    logic [63:0] mstatus_reg, mstatus_next;
    logic [63:0] mepc_reg, mepc_next, sepc_reg, sepc_next;
    logic [63:0] mcause_reg, mcause_next, scause_reg, scause_next;
    logic [63:0] mtval_reg, mtval_next, stval_reg, stval_next;
    logic [63:0] mtvec_reg, mtvec_next, stvec_reg, stvec_next;
    logic [15:0] medeleg_reg, medeleg_next;
    logic [11:0] mideleg_reg, mideleg_next;
    logic [63:0] mie_reg, mie_next, mip_reg, mip_next;

    rtcu_raw_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (acc),
        .rd_addr  (req.csr_addr),
        .wr_en    (raw_we),
        .wr_addr  (s1_req_reg.csr_addr),
        .wr_data  (s1_req_reg.write_data),
        .clearing (clearing),
        .rd_data  (raw_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (acc)
        begin
            fwd_hit_reg <= raw_we && (s1_req_reg.csr_addr == req.csr_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            fwd_data_reg <= s1_req_reg.write_data;
        end
    end

    logic is_named;
    always_comb
    begin
        case (s1_req_reg.csr_addr)
            A_SSTATUS, A_SIE, A_STVEC, A_SEPC, A_SCAUSE, A_STVAL, A_SIP,
            A_MSTATUS, A_MEDELEG, A_MIDELEG, A_MIE, A_MTVEC, A_MEPC,
            A_MCAUSE, A_MTVAL, A_MIP: is_named = 1'b1;
            default:                  is_named = 1'b0;
        endcase
    end

    assign raw_we = s1_valid_reg && (s1_req_reg.opcode == OP_CSR) && s1_req_reg.want_write
                    && !is_named;

    rsp_t        rsp;
    logic [63:0] sm, dlg64, wv;
    logic [63:0] cause_v, pvec;
    logic [3:0]  code;
    logic        is_int, do_trap, to_s, keep_tval, en, found;
    logic [3:0]  irq_order [9];

    assign irq_order = '{4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5, 4'd8, 4'd0, 4'd4};

    always_comb
    begin
        priv_next    = priv_reg;
        mstatus_next = mstatus_reg;
        mepc_next    = mepc_reg;
        sepc_next    = sepc_reg;
        mcause_next  = mcause_reg;
        scause_next  = scause_reg;
        mtval_next   = mtval_reg;
        stval_next   = stval_reg;
        mtvec_next   = mtvec_reg;
        stvec_next   = stvec_reg;
        medeleg_next = medeleg_reg;
        mideleg_next = mideleg_reg;
        mie_next     = mie_reg;
        mip_next     = mip_reg;
        rsp          = '0;
        sm           = S_IRQ_MASK & {52'h0, mideleg_reg};
        wv           = s1_req_reg.write_data;
        code         = s1_req_reg.trap_cause;
        is_int       = s1_req_reg.trap_is_interrupt;
        do_trap      = 1'b0;
        found        = 1'b0;
        en           = 1'b0;
        pvec         = mie_reg & mip_reg;

        unique case (s1_req_reg.opcode)
            OP_CSR:
            begin
                if (s1_req_reg.want_read)
                begin
                    case (s1_req_reg.csr_addr)
                        A_SSTATUS: rsp.read_data = mstatus_reg & SS_RMASK;
                        A_SIE:     rsp.read_data = mie_reg & sm;
                        A_STVEC:   rsp.read_data = stvec_reg;
                        A_SEPC:    rsp.read_data = sepc_reg;
                        A_SCAUSE:  rsp.read_data = scause_reg;
                        A_STVAL:   rsp.read_data = stval_reg;
                        A_SIP:     rsp.read_data = mip_reg & sm;
                        A_MSTATUS: rsp.read_data = mstatus_reg;
                        A_MEDELEG: rsp.read_data = {48'h0, medeleg_reg};
                        A_MIDELEG: rsp.read_data = {52'h0, mideleg_reg};
                        A_MIE:     rsp.read_data = mie_reg;
                        A_MTVEC:   rsp.read_data = mtvec_reg;
                        A_MEPC:    rsp.read_data = mepc_reg;
                        A_MCAUSE:  rsp.read_data = mcause_reg;
                        A_MTVAL:   rsp.read_data = mtval_reg;
                        A_MIP:     rsp.read_data = mip_reg;
                        default:
                        begin
                            if ({1'b0, s1_req_reg.csr_addr} < 13'(CSR_SPACE))
                            begin
                                rsp.read_data = fwd_hit_reg ? fwd_data_reg : raw_rd;
                            end
                        end
                    endcase
                end
                if (s1_req_reg.want_write)
                begin
                    case (s1_req_reg.csr_addr)
                        A_SSTATUS: mstatus_next = (mstatus_reg & ~SS_WMASK) | (wv & SS_WMASK);
                        A_SIE:     mie_next = (mie_reg & ~sm) | (wv & sm);
                        A_STVEC:   stvec_next = wv;
                        A_SEPC:    sepc_next = wv;
                        A_SCAUSE:  scause_next = wv;
                        A_STVAL:   stval_next = wv;
                        A_SIP:     mip_next = (mip_reg & ~sm) | (wv & sm);
                        A_MSTATUS: mstatus_next = wv;
                        A_MEDELEG: medeleg_next = wv[15:0] & EDELEG_MASK[15:0];
                        A_MIDELEG: mideleg_next = wv[11:0] & S_IRQ_MASK[11:0];
                        A_MIE:     mie_next = wv;
                        A_MTVEC:   mtvec_next = wv;
                        A_MEPC:    mepc_next = wv;
                        A_MCAUSE:  mcause_next = wv;
                        A_MTVAL:   mtval_next = wv;
                        A_MIP:     mip_next = wv;
                        default:   ;
                    endcase
                    if (s1_req_reg.csr_addr == A_SSTATUS || s1_req_reg.csr_addr == A_MSTATUS)
                    begin
                        mstatus_next[63] = &mstatus_next[14:13];
                    end
                end
            end
            OP_TRAP:
            begin
                do_trap = 1'b1;
            end
            OP_SRET:
            begin
                mstatus_next[1] = mstatus_reg[5];
                mstatus_next[5] = 1'b1;
                priv_next       = {1'b0, mstatus_reg[8]};
                mstatus_next[8] = 1'b0;
                rsp.next_pc     = sepc_reg;
                rsp.redirect    = 1'b1;
            end
            OP_MRET:
            begin
                if (mstatus_reg[12:11] == 2'd2)
                begin
                    rsp.fault = 1'b1;
                end
                else
                begin
                    mstatus_next[3]     = mstatus_reg[7];
                    mstatus_next[7]     = 1'b1;
                    priv_next           = mstatus_reg[12:11];
                    mstatus_next[12:11] = 2'd0;
                    rsp.next_pc         = mepc_reg;
                    rsp.redirect        = 1'b1;
                end
            end
            OP_POLL:
            begin
                // fixed priority, first enabled pending interrupt wins
                for (int i = 0; i < 9; i++)
                begin
                    if (mideleg_reg[irq_order[i]])
                    begin
                        en = (priv_reg == 2'd1 && mstatus_reg[1]) || priv_reg == 2'd0;
                    end
                    else
                    begin
                        en = (priv_reg == 2'd3 && mstatus_reg[3]) || priv_reg != 2'd3;
                    end
                    if (!found && pvec[irq_order[i]] && en)
                    begin
                        found  = 1'b1;
                        code   = irq_order[i];
                    end
                end
                is_int  = 1'b1;
                do_trap = found;
            end
            default: ;
        endcase

        dlg64     = is_int ? {52'h0, mideleg_reg} : {48'h0, medeleg_reg};
        to_s      = dlg64[code] && priv_reg != 2'd3;
        keep_tval = !is_int && (code == 4'd12 || code == 4'd13 || code == 4'd15
                                || code == 4'd4 || code == 4'd6);
        cause_v   = {is_int, 59'h0, code};
        if (do_trap)
        begin
            rsp.redirect = 1'b1;
            if (to_s)
            begin
                scause_next     = cause_v;
                sepc_next       = s1_req_reg.current_pc;
                mstatus_next[8] = priv_reg[0];
                mstatus_next[5] = mstatus_reg[1];
                mstatus_next[1] = 1'b0;
                if (!keep_tval)
                begin
                    stval_next = '0;
                end
                priv_next   = 2'd1;
                rsp.next_pc = stvec_reg;
            end
            else
            begin
                mcause_next         = cause_v;
                mepc_next           = s1_req_reg.current_pc;
                mstatus_next[12:11] = priv_reg;
                mstatus_next[7]     = mstatus_reg[3];
                mstatus_next[3]     = 1'b0;
                if (!keep_tval)
                begin
                    mtval_next = '0;
                end
                priv_next   = 2'd3;
                rsp.next_pc = mtvec_reg;
            end
        end
        rsp.mode_now = priv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            priv_reg       <= 2'd3;
            mstatus_reg    <= '0;
            mepc_reg       <= '0;
            sepc_reg       <= '0;
            mcause_reg     <= '0;
            scause_reg     <= '0;
            mtval_reg      <= '0;
            stval_reg      <= '0;
            mtvec_reg      <= '0;
            stvec_reg      <= '0;
            medeleg_reg    <= '0;
            mideleg_reg    <= '0;
            mie_reg        <= '0;
            mip_reg        <= '0;
        end
        else
        begin
            s1_valid_reg <= acc;
            if (advance)
            begin
                priv_reg    <= priv_next;
                mstatus_reg <= mstatus_next;
                mepc_reg    <= mepc_next;
                sepc_reg    <= sepc_next;
                mcause_reg  <= mcause_next;
                scause_reg  <= scause_next;
                mtval_reg   <= mtval_next;
                stval_reg   <= stval_next;
                mtvec_reg   <= mtvec_next;
                stvec_reg   <= stvec_next;
                medeleg_reg <= medeleg_next;
                mideleg_reg <= mideleg_next;
                mie_reg     <= mie_next;
                mip_reg     <= mip_next;
            end
            // output register with one skid entry
            if (!out_valid_reg || m_tready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= advance;
                end
                else
                begin
                    out_valid_reg <= advance;
                end
            end
            else if (advance)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_req_reg <= req;
        end
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (advance)
                begin
                    skid_reg <= rsp;
                end
            end
            else if (advance)
            begin
                out_reg <= rsp;
            end
        end
        else if (advance)
        begin
            skid_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_reg.mode_now, out_reg.fault, out_reg.redirect,
                       out_reg.next_pc, out_reg.read_data};
endmodule
